/* sv/wtu_pkg.sv */
// ----------------------------------------------------------------------------
// wtu_pkg
// Window type codes, fixed-point constants and series tables shared by the
// window taper unit.
// ----------------------------------------------------------------------------
package wtu_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 17;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 17;

  // window type codes
  localparam logic [2:0] WT_HANN     = 3'd0;
  localparam logic [2:0] WT_HAMMING  = 3'd1;
  localparam logic [2:0] WT_WELCH    = 3'd2;
  localparam logic [2:0] WT_BLACKMAN = 3'd3;
  localparam logic [2:0] WT_PARZEN   = 3'd4;
  localparam logic [2:0] WT_COSINE   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_TYPE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEGIN_FRACTION = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_FRACTION   = 3'd3;

  // Q30 constants
  localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
  localparam logic [31:0] PI_Q30        = 32'd3373259426;
  localparam logic [31:0] HAM_BASE_Q30  = 32'd85899346;
  localparam logic [31:0] HAM_SLOPE_Q30 = 32'd493921239;
  localparam logic [31:0] BLK_C2_Q30    = 32'd85899346;

  localparam logic [17:0] COEF_ONE      = 18'h20000;
  localparam logic [16:0] LEN_RESET     = 17'd1024;
  localparam logic [16:0] FRAC_RESET    = 17'd3277;
  localparam logic [16:0] LEN_MAX       = 17'h10000;

  // Horner divisors of the truncated cosine (8 terms) and sine (7 terms) series
  function automatic logic [7:0] term_div(input logic is_sin, input logic [2:0] k);
    logic [7:0] d;
    if (is_sin) begin
      case (k)
        3'd0:    d = 8'd210;
        3'd1:    d = 8'd156;
        3'd2:    d = 8'd110;
        3'd3:    d = 8'd72;
        3'd4:    d = 8'd42;
        3'd5:    d = 8'd20;
        default: d = 8'd6;
      endcase
    end else begin
      case (k)
        3'd0:    d = 8'd240;
        3'd1:    d = 8'd182;
        3'd2:    d = 8'd132;
        3'd3:    d = 8'd90;
        3'd4:    d = 8'd56;
        3'd5:    d = 8'd30;
        3'd6:    d = 8'd12;
        default: d = 8'd2;
      endcase
    end
    return d;
  endfunction

  // floor(2^32 / term_div), never above the true reciprocal
  function automatic logic [31:0] term_recip(input logic is_sin, input logic [2:0] k);
    logic [31:0] r;
    if (is_sin) begin
      case (k)
        3'd0:    r = 32'd20452225;
        3'd1:    r = 32'd27531841;
        3'd2:    r = 32'd39045157;
        3'd3:    r = 32'd59652323;
        3'd4:    r = 32'd102261126;
        3'd5:    r = 32'd214748364;
        default: r = 32'd715827882;
      endcase
    end else begin
      case (k)
        3'd0:    r = 32'd17895697;
        3'd1:    r = 32'd23598721;
        3'd2:    r = 32'd32537631;
        3'd3:    r = 32'd47721858;
        3'd4:    r = 32'd76695844;
        3'd5:    r = 32'd143165576;
        3'd6:    r = 32'd357913941;
        default: r = 32'd2147483648;
      endcase
    end
    return r;
  endfunction

endpackage

/* sv/window_taper_unit.sv */
// Each result waits in S_EMIT while the previous output is still stalled.
//   Cosine windows: a serial divide per phase (serial divider, one quotient
//   bit a cycle) plus the cosine/sine series on the shared multiplier.
//   The last sample of a window adds the normalization divide.
// Throughput: one sample at a time; in_stall is high from accept to result.
// Reset (rst_n low, synchronous): registers back to defaults, window restarts.
// ----------------------------------------------------------------------------
// window_taper_unit
// Multiplies each sample by a taper coefficient and reports the window's
// normalization factor on its last sample.
// ----------------------------------------------------------------------------
module window_taper_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [wtu_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [wtu_pkg::CFG_DATA_BITS-1:0]       cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [wtu_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [wtu_pkg::SAMPLE_BITS-1:0]  out_sample_out,
  output logic                                    out_window_end,
  output logic [19:0]                             out_norm_factor
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_TLB, S_TLE, S_TLF, S_SEL, S_DIV,
    S_OMC0, S_OMC1, S_OMC2, S_TRM_A, S_TRM_B, S_TRM_C, S_TRM_D,
    S_SIN, S_OMCF, S_POST, S_HAM, S_BLK, S_CEND, S_CMIX,
    S_WEL1, S_WEL2, S_WEL3, S_QCOEF, S_ACC, S_OMUL, S_ONORM, S_NORM, S_EMIT
  } state_t;

  typedef enum logic [2:0] {J_HANN, J_HAM, J_BLK1, J_BLK2, J_CB, J_CE} job_t;

  // divider step counts minus one: 34 numerator bits plus the shift
  localparam logic [6:0] DL_PH = 7'd66;  // phase, 33 extra bits
  localparam logic [6:0] DL_CF = 7'd51;  // welch/parzen coefficient
  localparam logic [6:0] DL_NM = 7'd67;  // normalization

  state_t        state_r, ret_r;
  job_t          job_r;

  logic [2:0]    wtype_r;
  logic [16:0]   wlen_r, bfrac_r, efrac_r;
  logic [15:0]   pos_r, i_r;
  logic [35:0]   sum_r;
  logic [17:0]   tcnt_r;
  logic [16:0]   blen_r, elen_r;

  logic signed [23:0] samp_r;
  logic [17:0]   coef_r;
  logic [31:0]   u_r;
  logic [30:0]   a_r;
  logic [30:0]   x_r, t_r, q0_r;
  logic [31:0]   x2_r, v_r;
  logic [1:0]    quad_r;
  logic [2:0]    k_r;
  logic [32:0]   wden_r;
  logic [63:0]   prod_r;
  logic [23:0]   res_r;
  logic [19:0]   norm_r;

  // serial divider
  logic [33:0]   num_r, dq_r;
  logic [35:0]   den_r, rem_r;
  logic          ovf_r;
  logic [6:0]    dcnt_r, dlast_r;

  logic          out_valid_r, out_end_r;
  logic [23:0]   out_sample_r;
  logic [19:0]   out_norm_r;

  // ---------------- derived values ----------------
  logic [16:0] len_w, lenm1_w, lenp1_w, twoi_w, rev_w, wel_d_w, par_d_w, par_n_w;
  logic        last_w;
  logic [34:0] rq_sum_w;
  logic [33:0] rq_w;
  logic [34:0] tl_sum_w;
  logic [18:0] tl_m_w;
  logic [16:0] tl_cap_w;

  always_comb begin
    if (wlen_r == 17'd0)                 len_w = 17'd1;
    else if (wlen_r > wtu_pkg::LEN_MAX)  len_w = wtu_pkg::LEN_MAX;
    else                                 len_w = wlen_r;
  end

  assign lenm1_w = len_w - 17'd1;
  assign lenp1_w = len_w + 17'd1;
  assign twoi_w  = {i_r, 1'b0};
  assign rev_w   = lenm1_w - {1'b0, i_r};
  assign last_w  = ({1'b0, i_r} == lenm1_w);
  assign wel_d_w = (twoi_w >= lenm1_w) ? twoi_w - lenm1_w : lenm1_w - twoi_w;
  assign par_d_w = (twoi_w >= len_w) ? twoi_w - len_w : len_w - twoi_w;
  assign par_n_w = lenp1_w - par_d_w;

  assign rq_sum_w = {1'b0, dq_r} + 35'd1;
  assign rq_w     = rq_sum_w[34:1];

  // taper length: round(frac * len / 65536), capped at len
  assign tl_sum_w = {1'b0, prod_r[33:0]} + 35'd32768;
  assign tl_m_w   = tl_sum_w[34:16];
  assign tl_cap_w = (tl_m_w > {2'b0, len_w}) ? len_w : tl_m_w[16:0];

  function automatic logic [17:0] to_coef(input logic [32:0] t30);
    logic [33:0] s;
    s = {1'b0, t30} + 34'd4096;
    return (s[33:13] > {3'b0, wtu_pkg::COEF_ONE}) ? wtu_pkg::COEF_ONE : s[30:13];
  endfunction

  // series term
  logic [7:0]  dk_w;
  logic [31:0] recip_w, rem_t_w, qv_w;
  logic [30:0] t_nxt;
  logic        term_done_w;

  assign dk_w        = wtu_pkg::term_div(quad_r[0], k_r);
  assign recip_w     = wtu_pkg::term_recip(quad_r[0], k_r);
  assign rem_t_w     = v_r - prod_r[31:0];
  assign qv_w        = {1'b0, q0_r} + ((rem_t_w >= {24'b0, dk_w}) ? 32'd1 : 32'd0);
  assign t_nxt       = (qv_w >= {1'b0, wtu_pkg::Q30_ONE}) ? 31'd0
                       : 31'(({1'b0, wtu_pkg::Q30_ONE}) - qv_w);
  assign term_done_w = quad_r[0] ? (k_r == 3'd6) : (k_r == 3'd7);

  // 1 - cos from the series result by quadrant
  logic [30:0] f_w;
  logic [31:0] u_w;
  assign f_w = quad_r[0] ? ((prod_r[60:30] > wtu_pkg::Q30_ONE) ? wtu_pkg::Q30_ONE
                                                                : prod_r[60:30])
                         : t_r;
  assign u_w = (quad_r[0] ^ quad_r[1]) ? {1'b0, wtu_pkg::Q30_ONE} + {1'b0, f_w}
                                       : {1'b0, wtu_pkg::Q30_ONE} - {1'b0, f_w};

  logic [17:0] cpost_w;
  assign cpost_w = to_coef({2'b0, u_r[31:1]});

  logic [30:0] blk_b_w;
  assign blk_b_w = {3'b0, prod_r[57:30]};

  logic [35:0] mix_w;
  assign mix_w = prod_r[35:0] + 36'd65536;

  // output sample
  logic        neg_w;
  logic [23:0] mag_w, p24_w;
  logic [40:0] psum_w;
  assign neg_w  = samp_r[23];
  assign mag_w  = neg_w ? 24'(~samp_r + 24'sd1) : samp_r;
  assign psum_w = prod_r[40:0] + 41'd65536;
  assign p24_w  = psum_w[40:17];

  // divider step
  logic [36:0] rem_sh_w;
  logic        ge_w;
  logic [35:0] rem_nxt;
  assign rem_sh_w = {rem_r, num_r[33]};
  assign ge_w     = rem_sh_w >= {1'b0, den_r};
  assign rem_nxt  = ge_w ? 36'(rem_sh_w - {1'b0, den_r}) : rem_sh_w[35:0];

  // divider start requests
  logic        ds_go;
  logic [33:0] ds_num;
  logic [35:0] ds_den;
  logic [6:0]  ds_last;
  state_t      ds_ret;
  job_t        ds_job;

  always_comb begin
    ds_go   = 1'b0;
    ds_num  = '0;
    ds_den  = '0;
    ds_last = DL_PH;
    ds_ret  = S_OMC0;
    ds_job  = job_r;
    case (state_r)
      S_SEL: begin
        case (wtype_r)
          wtu_pkg::WT_HANN, wtu_pkg::WT_HAMMING, wtu_pkg::WT_BLACKMAN: begin
            if (len_w > 17'd1) begin
              ds_go  = 1'b1;
              ds_num = 34'(i_r);
              ds_den = 36'(lenm1_w);
              ds_job = (wtype_r == wtu_pkg::WT_HANN) ? J_HANN :
                       (wtype_r == wtu_pkg::WT_HAMMING) ? J_HAM : J_BLK1;
            end
          end
          wtu_pkg::WT_PARZEN: begin
            ds_go   = 1'b1;
            ds_num  = 34'(par_n_w);
            ds_den  = 36'(lenp1_w);
            ds_last = DL_CF;
            ds_ret  = S_QCOEF;
          end
          wtu_pkg::WT_COSINE: begin
            if ({1'b0, i_r} < blen_r) begin
              ds_go  = 1'b1;
              ds_num = 34'(i_r);
              ds_den = 36'({blen_r, 1'b0});
              ds_job = J_CB;
            end
          end
          default: ;
        endcase
      end
      S_POST: begin
        if (job_r == J_BLK1) begin
          ds_go  = 1'b1;
          ds_num = 34'(twoi_w);
          ds_den = 36'(lenm1_w);
          ds_job = J_BLK2;
        end
      end
      S_CEND: begin
        if (rev_w < elen_r) begin
          ds_go  = 1'b1;
          ds_num = 34'(rev_w);
          ds_den = 36'({elen_r, 1'b0});
          ds_job = J_CE;
        end
      end
      S_WEL3: begin
        ds_go   = 1'b1;
        ds_num  = 34'(wden_r - prod_r[32:0]);
        ds_den  = 36'(wden_r);
        ds_last = DL_CF;
        ds_ret  = S_QCOEF;
      end
      S_ONORM: begin
        if (last_w && sum_r != 36'd0) begin
          ds_go   = 1'b1;
          ds_num  = (wtype_r == wtu_pkg::WT_COSINE) ? 34'(tcnt_r) : 34'(len_w);
          ds_den  = sum_r;
          ds_last = DL_NM;
          ds_ret  = S_NORM;
        end
      end
      default: ;
    endcase
  end

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TLB:   begin mul_a = 32'(bfrac_r);        mul_b = 32'(len_w); end
      S_TLE:   begin mul_a = 32'(efrac_r);        mul_b = 32'(len_w); end
      S_OMC0:  begin mul_a = 32'(rq_w[29:0]);     mul_b = wtu_pkg::PI_Q30; end
      S_OMC1:  begin mul_a = 32'(prod_r[61:31]);  mul_b = 32'(prod_r[61:31]); end
      S_TRM_A: begin mul_a = x2_r;                mul_b = 32'(t_r); end
      S_TRM_B: begin mul_a = prod_r[61:30];       mul_b = recip_w; end
      S_TRM_C: begin mul_a = 32'(prod_r[62:32]);  mul_b = 32'(dk_w); end
      S_SIN:   begin mul_a = 32'(x_r);            mul_b = 32'(t_r); end
      S_POST: begin
        case (job_r)
          J_HAM:   begin mul_a = u_r;          mul_b = wtu_pkg::HAM_SLOPE_Q30; end
          J_BLK2:  begin mul_a = u_r;          mul_b = wtu_pkg::BLK_C2_Q30; end
          J_CE:    begin mul_a = 32'(coef_r);  mul_b = 32'(cpost_w); end
          default: ;
        endcase
      end
      S_WEL1:  begin mul_a = 32'(lenp1_w);  mul_b = 32'(lenp1_w); end
      S_WEL2:  begin mul_a = 32'(wel_d_w);  mul_b = 32'(wel_d_w); end
      S_OMUL:  begin mul_a = 32'(mag_w);    mul_b = 32'(coef_r); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      job_r       <= J_HANN;
      wtype_r     <= wtu_pkg::WT_HANN;
      wlen_r      <= wtu_pkg::LEN_RESET;
      bfrac_r     <= wtu_pkg::FRAC_RESET;
      efrac_r     <= wtu_pkg::FRAC_RESET;
      pos_r       <= '0;
      sum_r       <= '0;
      tcnt_r      <= '0;
      blen_r      <= '0;
      elen_r      <= '0;
      dcnt_r      <= '0;
      dlast_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            samp_r  <= in_sample_in;
            state_r <= S_START;
          end
        end
        S_START: begin
          if ({1'b0, pos_r} >= len_w) begin
            i_r    <= '0;
            sum_r  <= '0;
            tcnt_r <= '0;
          end else begin
            i_r <= pos_r;
          end
          state_r <= ({1'b0, pos_r} >= len_w || pos_r == 16'd0) ? S_TLB : S_SEL;
        end
        S_TLB: state_r <= S_TLE;
        S_TLE: begin
          blen_r  <= tl_cap_w;
          state_r <= S_TLF;
        end
        S_TLF: begin
          elen_r  <= tl_cap_w;
          state_r <= S_SEL;
        end
        S_SEL: begin
          coef_r <= wtu_pkg::COEF_ONE;
          case (wtype_r)
            wtu_pkg::WT_WELCH:  state_r <= S_WEL1;
            wtu_pkg::WT_COSINE: state_r <= S_CEND;
            default:            state_r <= S_ACC;   // length one, or rectangular
          endcase
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          num_r  <= {num_r[32:0], 1'b0};
          dq_r   <= {dq_r[32:0], ge_w};
          ovf_r  <= ovf_r | dq_r[33];
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == dlast_r) state_r <= ret_r;
        end
        S_OMC0: begin
          quad_r  <= rq_w[31:30];
          state_r <= S_OMC1;
        end
        S_OMC1: begin
          x_r     <= prod_r[61:31];
          state_r <= S_OMC2;
        end
        S_OMC2: begin
          x2_r    <= prod_r[61:30];
          t_r     <= wtu_pkg::Q30_ONE;
          k_r     <= '0;
          state_r <= S_TRM_A;
        end
        S_TRM_A: state_r <= S_TRM_B;
        S_TRM_B: begin
          v_r     <= prod_r[61:30];
          state_r <= S_TRM_C;
        end
        S_TRM_C: begin
          q0_r    <= prod_r[62:32];
          state_r <= S_TRM_D;
        end
        S_TRM_D: begin
          // reciprocal quotient is low by at most one
          t_r <= t_nxt;
          k_r <= k_r + 3'd1;
          if (term_done_w) state_r <= quad_r[0] ? S_SIN : S_OMCF;
          else             state_r <= S_TRM_A;
        end
        S_SIN: state_r <= S_OMCF;
        S_OMCF: begin
          u_r     <= u_w;
          state_r <= S_POST;
        end
        S_POST: begin
          case (job_r)
            J_HANN: begin
              coef_r  <= cpost_w;
              state_r <= S_ACC;
            end
            J_HAM:  state_r <= S_HAM;
            J_BLK1: a_r <= u_r[31:1];
            J_BLK2: state_r <= S_BLK;
            J_CB: begin
              coef_r  <= cpost_w;
              sum_r   <= sum_r + 36'(cpost_w);
              tcnt_r  <= tcnt_r + 18'd1;
              state_r <= S_CEND;
            end
            J_CE: begin
              sum_r   <= sum_r + 36'(cpost_w);
              tcnt_r  <= tcnt_r + 18'd1;
              state_r <= S_CMIX;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_HAM: begin
          coef_r  <= to_coef(33'(wtu_pkg::HAM_BASE_Q30) + 33'(prod_r[60:30]));
          state_r <= S_ACC;
        end
        S_BLK: begin
          coef_r  <= to_coef(33'((a_r > blk_b_w) ? a_r - blk_b_w : 31'd0));
          state_r <= S_ACC;
        end
        S_CEND: state_r <= S_OMUL;
        S_CMIX: begin
          coef_r  <= mix_w[34:17];
          state_r <= S_OMUL;
        end
        S_WEL1: state_r <= S_WEL2;
        S_WEL2: begin
          wden_r  <= prod_r[32:0];
          state_r <= S_WEL3;
        end
        S_WEL3: state_r <= S_QCOEF;
        S_QCOEF: begin
          coef_r  <= rq_w[17:0];
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_r + 36'(coef_r);
          state_r <= S_OMUL;
        end
        S_OMUL: state_r <= S_ONORM;
        S_ONORM: begin
          res_r   <= neg_w ? 24'(-p24_w) : p24_w;
          norm_r  <= last_w ? 20'h10000 : 20'd0;
          state_r <= S_EMIT;
        end
        S_NORM: begin
          norm_r  <= (ovf_r || rq_w > 34'hFFFFF) ? 20'hFFFFF : rq_w[19:0];
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res_r;
            out_end_r    <= last_w;
            out_norm_r   <= norm_r;
            if (last_w) begin
              pos_r  <= '0;
              sum_r  <= '0;
              tcnt_r <= '0;
            end else begin
              pos_r <= i_r + 16'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (ds_go) begin
        num_r   <= ds_num;
        den_r   <= ds_den;
        rem_r   <= '0;
        dq_r    <= '0;
        ovf_r   <= 1'b0;
        dcnt_r  <= '0;
        dlast_r <= ds_last;
        ret_r   <= ds_ret;
        job_r   <= ds_job;
        state_r <= S_DIV;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          wtu_pkg::REG_WINDOW_TYPE: begin
            wtype_r <= cfg_wdata[2:0];
            pos_r <= '0; sum_r <= '0; tcnt_r <= '0;
          end
          wtu_pkg::REG_WINDOW_LENGTH: begin
            wlen_r <= cfg_wdata;
            pos_r <= '0; sum_r <= '0; tcnt_r <= '0;
          end
          wtu_pkg::REG_BEGIN_FRACTION: begin
            bfrac_r <= cfg_wdata;
            pos_r <= '0; sum_r <= '0; tcnt_r <= '0;
          end
          wtu_pkg::REG_END_FRACTION: begin
            efrac_r <= cfg_wdata;
            pos_r <= '0; sum_r <= '0; tcnt_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_window_end  = out_end_r;
  assign out_norm_factor = out_norm_r;

endmodule

/* sv/wtu_checker.sv */
// ----------------------------------------------------------------------------
// wtu_checker
// Port-level checks for the window taper unit, bound into window_taper_unit.
// ----------------------------------------------------------------------------
module wtu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_sample_out,
  input logic        out_window_end,
  input logic [19:0] out_norm_factor
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out) &&
      $stable(out_window_end) && $stable(out_norm_factor))
    else $error("stalled result changed");

  // norm factor only on the last sample of a window
  a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_end |-> out_norm_factor == 20'd0)
    else $error("norm factor outside window end");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a request while busy");

  // reset leaves the unit empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind window_taper_unit wtu_checker u_wtu_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for window_taper_unit: a window predictor mirrors the
// taper, sum and norm arithmetic and every tapered sample is checked in order
// across all window types and random lengths and taper fractions, with random idling.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [23:0] smp;
  logic               last;
  logic [19:0]        norm;
} taper_result_t;

class taper_tracker;
  typedef longint unsigned u64;
  localparam u64 ONE30 = 64'd1 << 30;
  localparam u64 PI30 = 64'd3373259426;
  localparam u64 HAM_BASE = 64'd85899346;
  localparam u64 HAM_SLOPE = 64'd493921239;
  localparam u64 BLK_C2 = 64'd85899346;
  localparam u64 C_ONE = 64'd1 << 17;

  bit [2:0]  wtype = wtu_pkg::WT_HANN;
  bit [16:0] wlen = 17'd1024, bfrac = 17'd3277, efrac = 17'd3277;
  u64 pos, tsum, tcount, blen, elen;
  taper_result_t pending_taps[$];
  int errors;

  function void set_reg(bit [2:0] idx, bit [16:0] val);
    case (idx)
      wtu_pkg::REG_WINDOW_TYPE:    wtype = val[2:0];
      wtu_pkg::REG_WINDOW_LENGTH:  wlen = val;
      wtu_pkg::REG_BEGIN_FRACTION: bfrac = val;
      wtu_pkg::REG_END_FRACTION:   efrac = val;
      default: return;
    endcase
    pos = 0; tsum = 0; tcount = 0;
  endfunction

  function u64 rdiv(u64 num, u64 den, int bits);
    u64 q, r;
    if (den == 0) return 0;
    q = num / den;
    r = num % den;
    for (int k = 0; k <= bits; k++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function u64 sat_sub(u64 a, u64 b);
    return a > b ? a - b : 0;
  endfunction

  // truncated Horner series; odd selects the sine form
  function u64 series(u64 x, bit odd);
    u64 cdiv[8] = '{240, 182, 132, 90, 56, 30, 12, 2};
    u64 sdiv[7] = '{210, 156, 110, 72, 42, 20, 6};
    u64 x2, t, s;
    x2 = (x * x) >> 30;
    t = ONE30;
    for (int k = 0; k < (odd ? 7 : 8); k++)
      t = sat_sub(ONE30, ((x2 * t) >> 30) / (odd ? sdiv[k] : cdiv[k]));
    if (!odd) return t;
    s = (x * t) >> 30;
    return s > ONE30 ? ONE30 : s;
  endfunction

  function u64 vers(u64 p);
    u64 q, x;
    q = (p >> 30) & 3;
    x = ((p & (ONE30 - 1)) * PI30) >> 31;
    case (q)
      0: return ONE30 - series(x, 0);
      1: return ONE30 + series(x, 1);
      2: return ONE30 + series(x, 0);
      default: return ONE30 - series(x, 1);
    endcase
  endfunction

  function u64 turn(u64 num, u64 den);
    return rdiv(num, den, 32) & 64'hFFFF_FFFF;
  endfunction

  function u64 q17(u64 t30);
    u64 c;
    c = (t30 + (64'd1 << 12)) >> 13;
    return c > C_ONE ? C_ONE : c;
  endfunction

  function u64 edge_taper(u64 k, u64 m);
    return q17(vers(turn(k, 2 * m)) >> 1);
  endfunction

  function u64 taper_len(u64 frac, u64 len);
    u64 m;
    m = (frac * len + 32768) >> 16;
    return m > len ? len : m;
  endfunction

  function void note_sample(logic signed [23:0] smp);
    u64 len, i, coef, c2, mag, prod, d, den, num;
    taper_result_t r;
    len = wlen;
    if (len < 1) len = 1;
    if (len > 65536) len = 65536;
    if (pos >= len) begin
      pos = 0; tsum = 0; tcount = 0;
    end
    i = pos;
    if (i == 0) begin
      blen = taper_len(bfrac, len);
      elen = taper_len(efrac, len);
    end
    coef = C_ONE;
    case (wtype)
      wtu_pkg::WT_HANN: begin
        if (len > 1) coef = q17(vers(turn(i, len - 1)) >> 1);
        tsum += coef;
      end
      wtu_pkg::WT_HAMMING: begin
        if (len > 1) coef = q17(HAM_BASE + ((vers(turn(i, len - 1)) * HAM_SLOPE) >> 30));
        tsum += coef;
      end
      wtu_pkg::WT_WELCH: begin
        den = (len + 1) * (len + 1);
        d = (2 * i >= len - 1) ? 2 * i - (len - 1) : (len - 1) - 2 * i;
        coef = rdiv(den - d * d, den, 17);
        tsum += coef;
      end
      wtu_pkg::WT_BLACKMAN: begin
        if (len > 1)
          coef = q17(sat_sub(vers(turn(i, len - 1)) >> 1,
                             (vers(turn(2 * i, len - 1)) * BLK_C2) >> 30));
        tsum += coef;
      end
      wtu_pkg::WT_PARZEN: begin
        d = (2 * i >= len) ? 2 * i - len : len - 2 * i;
        coef = rdiv(len + 1 - d, len + 1, 17);
        tsum += coef;
      end
      wtu_pkg::WT_COSINE: begin
        if (i < blen) begin
          coef = edge_taper(i, blen);
          tsum += coef;
          tcount++;
        end
        if (len - 1 - i < elen) begin
          c2 = edge_taper(len - 1 - i, elen);
          tsum += c2;
          tcount++;
          coef = (coef * c2 + (C_ONE >> 1)) >> 17;
        end
      end
      default: tsum += coef;
    endcase
    mag = smp < 0 ? u64'(-longint'(smp)) : u64'(smp);
    prod = (mag * coef + (C_ONE >> 1)) >> 17;
    r.smp = smp < 0 ? 24'(-prod) : 24'(prod);
    r.last = (i == len - 1);
    r.norm = 0;
    if (r.last) begin
      num = (wtype == wtu_pkg::WT_COSINE) ? tcount : len;
      d = tsum ? rdiv(num, tsum, 33) : (64'd1 << 16);
      r.norm = d > 64'hFFFFF ? 20'hFFFFF : 20'(d);
      pos = 0; tsum = 0; tcount = 0;
    end else begin
      pos++;
    end
    pending_taps.push_back(r);
  endfunction

  function void check_result(logic signed [23:0] smp, logic last, logic [19:0] norm);
    taper_result_t e;
    if (pending_taps.size() == 0) begin
      $display("%0t: unexpected result smp=%0d end=%0b norm=%0d", $time, smp, last, norm);
      errors++;
      return;
    end
    e = pending_taps.pop_front();
    if (smp !== e.smp) begin
      $display("%0t: sample_out expected %0d actual %0d", $time, e.smp, smp);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: window_end expected %0b actual %0b", $time, e.last, last);
      errors++;
    end
    if (norm !== e.norm) begin
      $display("%0t: norm_factor expected %0d actual %0d", $time, e.norm, norm);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG_CYCLES = 6000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = 0;
  logic [16:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [23:0] in_sample_in = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [23:0] out_sample_out;
  logic out_window_end;
  logic [19:0] out_norm_factor;

  taper_tracker tracker = new();
  bit hold_out = 0;
  bit rx_steady = 0, tx_steady = 0;
  int sent = 0;
  int idle_cycles = 0;

  window_taper_unit uut (.*);

  always #6 clk = ~clk;

  // result side: random stall, one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall = 1;
        repeat (400) @(negedge clk);
        hold_out = 0;
      end
      if (rx_steady) out_stall = 0;
      else if ($urandom_range(0, 99) < 70) out_stall = 0;
      else out_stall = 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_sample_out, out_window_end, out_norm_factor);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic pause_cycles();
    int n;
    n = $urandom_range(0, 99);
    if (tx_steady || n < 65) return;
    in_valid = 0;
    if (n < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(20, 80)) @(negedge clk);
  endtask

  task automatic send_sample(logic signed [23:0] smp);
    in_valid = 1;
    in_sample_in = smp;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    tracker.note_sample(smp);
    sent++;
    @(negedge clk);
    in_valid = 0;
    pause_cycles();
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return 24'(int'($urandom_range(0, 8)) - 4);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (tracker.pending_taps.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic run_window(logic [2:0] wt, logic [16:0] len, logic [16:0] bf,
                            logic [16:0] ef, int n);
    drain();
    write_reg(wtu_pkg::REG_WINDOW_TYPE, wt);
    write_reg(wtu_pkg::REG_WINDOW_LENGTH, len);
    write_reg(wtu_pkg::REG_BEGIN_FRACTION, bf);
    write_reg(wtu_pkg::REG_END_FRACTION, ef);
    repeat (n) send_sample(pick_sample());
  endtask

  initial begin
    int len, n;
    logic [2:0] wt;
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // reset settings, extreme samples
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh000000);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    // writes beyond the register list leave the window running
    drain();
    write_reg(3'd4, 17'h1FFFF);
    write_reg(3'd7, 17'h0);
    send_sample(24'sh555555);

    // length one, short windows, out-of-range lengths and unknown types
    for (int t = 0; t < 8; t++) run_window(3'(t), 17'd1, 17'd0, 17'd0, 2);
    run_window(wtu_pkg::WT_HANN, 17'd0, 17'd0, 17'd0, 2);
    run_window(wtu_pkg::WT_BLACKMAN, 17'd2, 17'd0, 17'd0, 2);
    run_window(wtu_pkg::WT_COSINE, 17'd3, 17'h1FFFF, 17'h10000, 3);
    run_window(wtu_pkg::WT_COSINE, 17'd4, 17'd0, 17'd0, 4);
    run_window(wtu_pkg::WT_WELCH, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 2);

    // long receiver hold while the sender keeps offering
    drain();
    hold_out = 1;
    run_window(wtu_pkg::WT_HAMMING, 17'd7, 17'd0, 17'd0, 14);

    while (sent < 1850) begin
      wt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      n = $urandom_range(0, 99);
      if (n < 85) len = $urandom_range(1, 48);
      else if (n < 97) len = $urandom_range(100, 300);
      else len = $urandom_range(0, 1) ? 65536 : 131071;
      n = (len > 300) ? 6 : len * $urandom_range(1, 3) + $urandom_range(0, len);
      if (n > 320) n = 320;
      rx_steady = ($urandom_range(0, 5) == 0);
      tx_steady = ($urandom_range(0, 5) == 0);
      run_window(wt, 17'(len),
                 $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                 $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                 n);
    end

    drain();
    repeat (200) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_taps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/wtu_pkg.sv
sv/window_taper_unit.sv
sv/wtu_checker.sv
verif/tb_top.sv
